// File: rtl/ftss_pkg.sv
// ----------------------------------------------------------------------------
// ftss_pkg - four-track step sequencer shared definitions
// Register indexes, step mode codes, widths, config bundle and FSM encoding.
// ----------------------------------------------------------------------------
package ftss_pkg;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_STEP_MODES  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BACKWARD    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_GUARD_TICKS = 2'd2;

    localparam logic [15:0] GUARD_TICKS_RST = 16'd48;

    // Step modes, two bits per step
    localparam logic [1:0] MODE_NORMAL  = 2'd0;
    localparam logic [1:0] MODE_SKIP    = 2'd1;
    localparam logic [1:0] MODE_RESTART = 2'd2;

    // Stream widths (whole bytes)
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic [15:0] step_modes;
        logic [3:0]  backward;
        logic [15:0] guard_ticks;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_TRACK = 4'b0010,
        ST_WALK  = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

endpackage

// File: rtl/ftss_cfg.sv
// ----------------------------------------------------------------------------
// ftss_cfg - configuration register bank
// Write-only registers decoded from the plain write port.
// ----------------------------------------------------------------------------
module ftss_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [ftss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ftss_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output ftss_pkg::cfg_t                   cfg
);

    ftss_pkg::cfg_t cfg_reg;
    ftss_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                ftss_pkg::REG_STEP_MODES:  cfg_next.step_modes  = cfg_wr_data;
                ftss_pkg::REG_BACKWARD:    cfg_next.backward    = cfg_wr_data[3:0];
                ftss_pkg::REG_GUARD_TICKS: cfg_next.guard_ticks = cfg_wr_data;
                default:                   cfg_next = cfg_reg; // unused index
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_modes  <= '0;
            cfg_reg.backward    <= '0;
            cfg_reg.guard_ticks <= ftss_pkg::GUARD_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/ftss_walk.sv
// ----------------------------------------------------------------------------
// ftss_walk - shared step walker
// One wrapping move forward or backward plus step mode lookups.
// ----------------------------------------------------------------------------
module ftss_walk
#(
    parameter  int NUM_STEPS = 8,
    localparam int SW        = $clog2(NUM_STEPS)
)
(
    input  logic [15:0]   step_modes,
    input  logic [SW-1:0] cur,
    input  logic          backward,
    output logic [SW-1:0] nxt,
    output logic          nxt_skip,
    output logic          cur_restart
);

    localparam logic [SW-1:0] LAST_STEP = SW'(NUM_STEPS - 1);

    // steps eight and up have no mode bits and read as normal
    function automatic logic [1:0] mode_of(input logic [15:0] modes, input logic [SW-1:0] s);
        logic [SW+3:0] se;
        logic [1:0]    m;
        se = {4'b0000, s};
        if (se[SW+3:3] != '0)
            m = ftss_pkg::MODE_NORMAL;
        else
            m = modes[{se[2:0], 1'b0} +: 2];
        return m;
    endfunction

    always_comb
    begin
        if (backward)
            nxt = (cur == '0) ? LAST_STEP : cur - 1'b1;
        else
            nxt = (cur == LAST_STEP) ? '0 : cur + 1'b1;
    end

    assign nxt_skip    = (mode_of(step_modes, nxt) == ftss_pkg::MODE_SKIP);
    assign cur_restart = (mode_of(step_modes, cur) == ftss_pkg::MODE_RESTART);

endmodule

// File: rtl/four_track_step_sequencer_unit.sv
// ----------------------------------------------------------------------------
// four_track_step_sequencer_unit - step sequencer tracks over a shared mode table
// Each tick visits the tracks in turn; a shared walker moves steps past skips.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload (low bit first)
//  s_axis    in         tick flags, one transaction per tick
//  m_axis    out        track steps, gates and step pulses, one per tick
//  cfg       in         write-only register port, no handshake
//
//  Walks  : a track whose clock rise needs a walk (no forced step, no
//           return-to-start step) hands over to the single shared walker,
//           which moves one step a cycle.
//  Reset  : rst_n clears all control and track state at once; no clearing
//           pass is needed.
//  Stalls : s_axis_tready is high only between ticks. A finished result sits
//           in the output register; the next tick is taken meanwhile and only
//           waits at its end if that result has not yet been taken.
// ----------------------------------------------------------------------------
module four_track_step_sequencer_unit
#(
    parameter int NUM_STEPS  = 8,
    parameter int NUM_TRACKS = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    // master_reset[0], track_reset[4:1], clock_rise[8:5], clock_fall[12:9],
    // direction_level[16:13], force_valid[17], force_index[20:18], zero pad
    input  logic [ftss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // step_track0[2:0], step_track1[5:3], step_track2[8:6], step_track3[11:9],
    // gates[15:12], step_pulses[23:16]
    output logic [ftss_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_wr_en,
    input  logic [ftss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ftss_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

    localparam int SW = $clog2(NUM_STEPS);
    localparam int TW = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 1;

    localparam logic [SW-1:0] LAST_STEP  = SW'(NUM_STEPS - 1);
    localparam logic [TW-1:0] LAST_TRACK = TW'(NUM_TRACKS - 1);

    // ------------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------------
    ftss_pkg::cfg_t cfg;

    ftss_cfg u_cfg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    // ------------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------------
    ftss_pkg::state_t state_reg, state_next;
    logic [TW-1:0]    idx_reg, idx_next;          // track being processed

    // latched tick
    logic             in_mrst_reg;
    logic [3:0]       in_trst_reg;
    logic [3:0]       in_rise_reg;
    logic [3:0]       in_fall_reg;
    logic [3:0]       in_dir_reg;
    logic             in_fvld_reg;
    logic [2:0]       in_fidx_reg;

    // track state
    logic [SW-1:0]    step_reg     [NUM_TRACKS];
    logic [SW-1:0]    step_next    [NUM_TRACKS];
    logic             pend_vld_reg [NUM_TRACKS];
    logic             pend_vld_next[NUM_TRACKS];
    logic [SW-1:0]    pend_idx_reg [NUM_TRACKS];
    logic [SW-1:0]    pend_idx_next[NUM_TRACKS];
    logic [15:0]      guard_reg    [NUM_TRACKS];
    logic [15:0]      guard_next   [NUM_TRACKS];
    logic [NUM_TRACKS-1:0] gate_reg, gate_next;
    logic [7:0]       pulse_reg, pulse_next;

    // walk sequencer
    logic [SW-1:0]    walk_s_reg, walk_s_next;
    logic [SW-1:0]    walk_cnt_reg, walk_cnt_next;
    logic             walk_back_reg, walk_back_next;

    // output register
    logic [ftss_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;
    logic             m_valid_reg, m_valid_next;

    // ------------------------------------------------------------------------
    // Per-track flags; only tracks 0..3 have edge and direction inputs
    // ------------------------------------------------------------------------
    logic [NUM_TRACKS-1:0] trst_ext, rise_ext, fall_ext, back_ext;

    for (genvar t = 0; t < NUM_TRACKS; t++)
    begin : g_flags
        if (t < 4)
        begin : g_wired
            assign trst_ext[t] = in_trst_reg[t];
            assign rise_ext[t] = in_rise_reg[t];
            assign fall_ext[t] = in_fall_reg[t];
            assign back_ext[t] = in_dir_reg[t] | cfg.backward[t];
        end
        else
        begin : g_unwired
            assign trst_ext[t] = 1'b0;
            assign rise_ext[t] = 1'b0;
            assign fall_ext[t] = 1'b0;
            assign back_ext[t] = 1'b0;
        end
    end

    // forced step: out-of-range index drops the trigger
    logic            force_ok;
    logic [SW+2:0]   fidx_wide;
    assign fidx_wide = {SW'(0), in_fidx_reg};
    assign force_ok  = in_fvld_reg && ({29'd0, in_fidx_reg} < 32'(NUM_STEPS));

    // ------------------------------------------------------------------------
    // Shared walker: current step of the track in TRACK, walk pointer in WALK
    // ------------------------------------------------------------------------
    logic [SW-1:0] walk_cur, walk_nxt;
    logic          walk_dir, walk_skip, cur_restart;

    assign walk_cur = (state_reg == ftss_pkg::ST_WALK) ? walk_s_reg : step_reg[idx_reg];
    assign walk_dir = (state_reg == ftss_pkg::ST_WALK) ? walk_back_reg : back_ext[idx_reg];

    ftss_walk #(.NUM_STEPS(NUM_STEPS)) u_walk
    (
        .step_modes  (cfg.step_modes),
        .cur         (walk_cur),
        .backward    (walk_dir),
        .nxt         (walk_nxt),
        .nxt_skip    (walk_skip),
        .cur_restart (cur_restart)
    );

    // pulse bit for a step; steps eight and up light nothing
    function automatic logic [7:0] pulse_of(input logic [SW-1:0] s);
        logic [SW+3:0] se;
        logic [7:0]    p;
        se = {4'b0000, s};
        if (se[SW+3:3] != '0)
            p = 8'd0;
        else
            p = 8'd1 << se[2:0];
        return p;
    endfunction

    // ------------------------------------------------------------------------
    // Result packing from the committed track state
    // ------------------------------------------------------------------------
    logic [2:0]              step3 [4];
    logic [NUM_TRACKS+3:0]   gate_wide;

    for (genvar k = 0; k < 4; k++)
    begin : g_out
        if (k < NUM_TRACKS)
        begin : g_live
            logic [SW+2:0] sw_wide;
            assign sw_wide  = {3'b000, step_reg[k]};
            assign step3[k] = sw_wide[2:0];
        end
        else
        begin : g_dead
            assign step3[k] = 3'b000;
        end
    end

    assign gate_wide = {4'b0000, gate_reg};

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    logic          g_zero, g_end, rst_t, is_t0;
    logic [15:0]   g_dec;
    logic          commit_en, adv_en, out_load;
    logic [SW-1:0] commit_val;

    assign g_zero = (guard_reg[idx_reg] == 16'd0);
    assign g_end  = (guard_reg[idx_reg] == 16'd1);
    assign g_dec  = guard_reg[idx_reg] - 16'd1;
    assign rst_t  = in_mrst_reg | trst_ext[idx_reg];  // master or track reset wins over clock and force inputs
    assign is_t0  = (idx_reg == '0);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        step_next      = step_reg;
        pend_vld_next  = pend_vld_reg;
        pend_idx_next  = pend_idx_reg;
        guard_next     = guard_reg;
        gate_next      = gate_reg;
        pulse_next     = pulse_reg;
        walk_s_next    = walk_s_reg;
        walk_cnt_next  = walk_cnt_reg;
        walk_back_next = walk_back_reg;
        commit_en      = 1'b0;
        commit_val     = walk_nxt;
        adv_en         = 1'b0;
        out_load       = 1'b0;

        case (state_reg)
            ftss_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ftss_pkg::ST_TRACK;
                    idx_next   = '0;
                end
            end

            ftss_pkg::ST_TRACK:
            begin
                adv_en = 1'b1;
                if (rst_t)
                begin
                    // a reset during the guard only ticks the guard down
                    if (!g_zero)
                    begin
                        guard_next[idx_reg] = g_dec;
                    end
                    else
                    begin
                        gate_next[idx_reg]     = 1'b0;
                        step_next[idx_reg]     = '0;
                        pend_vld_next[idx_reg] = 1'b0;
                        guard_next[idx_reg]    = cfg.guard_ticks;
                        if (is_t0)
                            pulse_next = 8'd1;
                    end
                end
                else if (!g_zero)
                begin
                    guard_next[idx_reg] = g_dec;
                    if (g_end)
                    begin
                        gate_next[idx_reg] = 1'b0;
                        if (is_t0)
                            pulse_next = 8'd0;
                    end
                end
                else
                begin
                    if (force_ok)
                    begin
                        pend_vld_next[idx_reg] = 1'b1;
                        pend_idx_next[idx_reg] = fidx_wide[SW-1:0];
                    end
                    if (rise_ext[idx_reg])
                    begin
                        if (force_ok || pend_vld_reg[idx_reg])
                        begin
                            commit_en              = 1'b1;
                            commit_val             = force_ok ? fidx_wide[SW-1:0]
                                                              : pend_idx_reg[idx_reg];
                            pend_vld_next[idx_reg] = 1'b0;
                        end
                        else if (cur_restart)
                        begin
                            commit_en  = 1'b1;
                            commit_val = back_ext[idx_reg] ? LAST_STEP : '0;
                        end
                        else
                        begin
                            // hand over to the walker, one move a cycle
                            adv_en         = 1'b0;
                            walk_s_next    = step_reg[idx_reg];
                            walk_cnt_next  = '0;
                            walk_back_next = back_ext[idx_reg];
                            state_next     = ftss_pkg::ST_WALK;
                        end
                    end
                    else if (fall_ext[idx_reg])
                    begin
                        gate_next[idx_reg] = 1'b0;
                        if (is_t0)
                            pulse_next = 8'd0;
                    end
                end
            end

            ftss_pkg::ST_WALK:
            begin
                // stop on a non-skip step, or after a full lap of skips
                if (!walk_skip || (walk_cnt_reg == LAST_STEP))
                begin
                    commit_en  = 1'b1;
                    commit_val = walk_nxt;
                    adv_en     = 1'b1;
                end
                else
                begin
                    walk_s_next   = walk_nxt;
                    walk_cnt_next = walk_cnt_reg + 1'b1;
                end
            end

            ftss_pkg::ST_DONE:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ftss_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ftss_pkg::ST_IDLE;
            end
        endcase

        // clock rise: new step, gate high, pulse bit ORed in for track 0
        if (commit_en)
        begin
            step_next[idx_reg] = commit_val;
            gate_next[idx_reg] = 1'b1;
            if (is_t0)
                pulse_next = pulse_reg | pulse_of(commit_val);
        end

        if (adv_en)
        begin
            if (idx_reg == LAST_TRACK)
            begin
                state_next = ftss_pkg::ST_DONE;
            end
            else
            begin
                idx_next   = idx_reg + 1'b1;
                state_next = ftss_pkg::ST_TRACK;
            end
        end
    end

    // output register
    always_comb
    begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_data_next  = {pulse_reg, gate_wide[3:0], step3[3], step3[2], step3[1], step3[0]};
            m_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ftss_pkg::ST_IDLE;
            idx_reg       <= '0;
            gate_reg      <= '0;
            pulse_reg     <= '0;
            walk_cnt_reg  <= '0;
            m_valid_reg   <= 1'b0;
            for (int t = 0; t < NUM_TRACKS; t++)
            begin
                step_reg[t]     <= '0;
                pend_vld_reg[t] <= 1'b0;
                guard_reg[t]    <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            gate_reg      <= gate_next;
            pulse_reg     <= pulse_next;
            walk_cnt_reg  <= walk_cnt_next;
            m_valid_reg   <= m_valid_next;
            step_reg      <= step_next;
            pend_vld_reg  <= pend_vld_next;
            guard_reg     <= guard_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_mrst_reg <= s_axis_tdata[0];
            in_trst_reg <= s_axis_tdata[4:1];
            in_rise_reg <= s_axis_tdata[8:5];
            in_fall_reg <= s_axis_tdata[12:9];
            in_dir_reg  <= s_axis_tdata[16:13];
            in_fvld_reg <= s_axis_tdata[17];
            in_fidx_reg <= s_axis_tdata[20:18];
        end
        pend_idx_reg  <= pend_idx_next;
        walk_s_reg    <= walk_s_next;
        walk_back_reg <= walk_back_next;
        m_data_reg    <= m_data_next;
    end

    assign s_axis_tready = (state_reg == ftss_pkg::ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_accept_starts_track0: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ftss_pkg::ST_TRACK) && (idx_reg == '0))
        else $error("tick accepted but track walk did not start at track 0");

    a_done_delivers: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ftss_pkg::ST_DONE) && (!m_valid_reg || m_axis_tready)) |=> m_valid_reg)
        else $error("finished tick not presented on the output");

    a_walk_not_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ftss_pkg::ST_WALK) |-> !cur_restart)
        else $error("walk started from a return-to-start step");

    a_pend_no_guard: assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg[0] |-> (guard_reg[0] == 16'd0))
        else $error("track 0 holds a forced step while its guard runs");

endmodule

// File: tb/four_track_step_sequencer_unit_checker.sv
// ----------------------------------------------------------------------------
// four_track_step_sequencer_unit_checker - tick predictor and result checker
// Watches the config port and both streams, predicts one result per tick and
// compares it field by field with what the block hands out.
// ----------------------------------------------------------------------------
module four_track_step_sequencer_unit_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [ftss_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [ftss_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             cfg_wr_en,
    input  logic [ftss_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [ftss_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    output int                               fault_count,
    output int                               results_checked,
    output int                               waiting_results
);
    import ftss_pkg::*;

    localparam int NUM_STEPS  = 8;
    localparam int NUM_TRACKS = 4;

    typedef enum logic [1:0] {
        GUARD_IDLE,
        GUARD_RUNNING,
        GUARD_ENDED
    } guard_phase_t;

    // Same bit layout as the stream payloads, top field first
    typedef struct packed {
        logic [2:0] pad;
        logic [2:0] force_index;
        logic       force_valid;
        logic [3:0] direction;
        logic [3:0] fall;
        logic [3:0] rise;
        logic [3:0] track_reset;
        logic       master_reset;
    } tick_t;

    typedef struct packed {
        logic [7:0] pulses;
        logic [3:0] gates;
        logic [2:0] step3;
        logic [2:0] step2;
        logic [2:0] step1;
        logic [2:0] step0;
    } result_t;

    logic [15:0]           mode_table;
    logic [3:0]            back_switches;
    logic [15:0]           guard_length;
    logic [2:0]            track_step [NUM_TRACKS];
    logic                  jump_armed [NUM_TRACKS];
    logic [2:0]            jump_target [NUM_TRACKS];
    logic [15:0]           guard_left [NUM_TRACKS];
    logic [NUM_TRACKS-1:0] gate_bits;
    logic [7:0]            pulse_bits;
    result_t               forecast_q [$];

    task automatic report_fault(input string msg);
        $display("checker: %s", msg);
        fault_count++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
            report_fault($sformatf("result %0d %s expected %0h got %0h",
                                   results_checked, name, want, got));
    endtask

    function automatic logic [1:0] mode_at(input logic [2:0] s);
        return mode_table[2*s +: 2];
    endfunction

    function automatic guard_phase_t guard_countdown(input int t);
        if (guard_left[t] == 16'd0)
            return GUARD_IDLE;
        guard_left[t]--;
        return (guard_left[t] == 16'd0) ? GUARD_ENDED : GUARD_RUNNING;
    endfunction

    task automatic drop_gate(input int t);
        gate_bits[t] = 1'b0;
        if (t == 0)
            pulse_bits = 8'd0;
    endtask

    task automatic raise_gate(input int t, input logic quiet);
        gate_bits[t] = !quiet;
        if (t == 0)
            pulse_bits[track_step[0]] = 1'b1;
    endtask

    // reset edge: ignored while a guard is still counting
    task automatic restart_track(input int t);
        if (guard_countdown(t) == GUARD_IDLE)
        begin
            drop_gate(t);
            track_step[t]  = 3'd0;
            jump_armed[t]  = 1'b0;
            guard_left[t]  = guard_length;
            raise_gate(t, 1'b1);
        end
    endtask

    task automatic advance_track(input int t, input logic backward);
        logic [2:0] s;
        int         k;
        s = track_step[t];
        if (jump_armed[t])
        begin
            track_step[t] = jump_target[t];
            jump_armed[t] = 1'b0;
        end
        else if (mode_at(s) == MODE_RESTART)
            track_step[t] = backward ? 3'(NUM_STEPS - 1) : 3'd0;
        else
        begin
            for (k = 0; k < NUM_STEPS; k++)
            begin
                if (backward)
                    s = (s == 3'd0) ? 3'(NUM_STEPS - 1) : s - 3'd1;
                else
                    s = (int'(s) + 1 >= NUM_STEPS) ? 3'd0 : s + 3'd1;
                if (mode_at(s) != MODE_SKIP)
                    break;
            end
            track_step[t] = s;
        end
    endtask

    task automatic run_tick(input tick_t tk, output result_t r);
        logic         jump_ok;
        guard_phase_t g;
        int           t;
        jump_ok = tk.force_valid && (int'(tk.force_index) < NUM_STEPS);
        for (t = 0; t < NUM_TRACKS; t++)
        begin
            if (tk.master_reset || tk.track_reset[t])
                restart_track(t);
            else
            begin
                g = guard_countdown(t);
                if (g == GUARD_IDLE)
                begin
                    if (jump_ok)
                    begin
                        jump_armed[t]  = 1'b1;
                        jump_target[t] = tk.force_index;
                    end
                    if (tk.rise[t])
                    begin
                        advance_track(t, tk.direction[t] | back_switches[t]);
                        raise_gate(t, 1'b0);
                    end
                    else if (tk.fall[t])
                        drop_gate(t);
                end
                else if (g == GUARD_ENDED)
                    drop_gate(t);
            end
        end
        r.step0  = track_step[0];
        r.step1  = track_step[1];
        r.step2  = track_step[2];
        r.step3  = track_step[3];
        r.gates  = gate_bits;
        r.pulses = pulse_bits;
    endtask

    initial
    begin
        fault_count     = 0;
        results_checked = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        result_t got;
        int      t;
        if (!rst_n)
        begin
            mode_table    = 16'd0;
            back_switches = 4'd0;
            guard_length  = GUARD_TICKS_RST;
            gate_bits     = '0;
            pulse_bits    = 8'd0;
            for (t = 0; t < NUM_TRACKS; t++)
            begin
                track_step[t]  = 3'd0;
                jump_armed[t]  = 1'b0;
                jump_target[t] = 3'd0;
                guard_left[t]  = 16'd0;
            end
            forecast_q.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = result_t'(m_axis_tdata);
                if (forecast_q.size() == 0)
                    report_fault($sformatf("result %0h arrived with no tick waiting",
                                           m_axis_tdata));
                else
                begin
                    want = forecast_q.pop_front();
                    check_field("step_track0", want.step0, got.step0);
                    check_field("step_track1", want.step1, got.step1);
                    check_field("step_track2", want.step2, got.step2);
                    check_field("step_track3", want.step3, got.step3);
                    check_field("gates", want.gates, got.gates);
                    check_field("step_pulses", want.pulses, got.pulses);
                end
                results_checked++;
            end
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_STEP_MODES:  mode_table    = cfg_wr_data;
                    REG_BACKWARD:    back_switches = cfg_wr_data[3:0];
                    REG_GUARD_TICKS: guard_length  = cfg_wr_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                run_tick(tick_t'(s_axis_tdata), want);
                forecast_q.push_back(want);
            end
        end
        waiting_results <= forecast_q.size();
    end

endmodule

// File: tb/four_track_step_sequencer_unit_test.sv
// ----------------------------------------------------------------------------
// four_track_step_sequencer_unit_test - stimulus and verdict for the sequencer
// Directed ticks, then random phases over several mode tables and guard
// lengths, with random gaps and stalls; the checker does all the comparing.
// ----------------------------------------------------------------------------
module four_track_step_sequencer_unit_test;
    import ftss_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int NUM_PHASES       = 8;
    localparam int PHASE_TICKS      = 204;
    // Receiver parks tready low once, mid-run, so the block fills and stalls.
    localparam int HOLD_AT          = 400;
    localparam int HOLD_CYCLES      = 96;
    // Run limit covers the worst tick (gap, full-circle walks, stall); x4 margin.
    localparam int RUN_LIMIT_CYCLES = 400000;
    localparam int DRAIN_LIMIT      = 2000;
    localparam int TAIL_CYCLES      = 48;

    logic                     clk;
    logic                     rst_n;
    logic [IN_DATA_W-1:0]     s_axis_tdata;
    logic                     s_axis_tvalid;
    logic                     s_axis_tready;
    logic [OUT_DATA_W-1:0]    m_axis_tdata;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready;
    logic                     cfg_wr_en;
    logic [CFG_ADDR_W-1:0]    cfg_addr;
    logic [CFG_DATA_W-1:0]    cfg_wr_data;

    int fault_count;
    int results_checked;
    int waiting_results;
    int sent_count;

    four_track_step_sequencer_unit dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data)
    );

    four_track_step_sequencer_unit_checker checker_i
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_addr        (cfg_addr),
        .cfg_wr_data     (cfg_wr_data),
        .fault_count     (fault_count),
        .results_checked (results_checked),
        .waiting_results (waiting_results)
    );

    initial clk = 1'b0;
    always
    begin
        #(CLK_PERIOD / 2) clk = 1'b1;
        #(CLK_PERIOD / 2) clk = 1'b0;
    end

    // Hard stop: a hung handshake or a missing result ends here
    initial
    begin
        #(RUN_LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout after %0d cycles", RUN_LIMIT_CYCLES);
        $display("status: fail");
        $finish;
    end

    // tick payload: master_reset[0], track_reset[4:1], clock_rise[8:5],
    // clock_fall[12:9], direction_level[16:13], force_valid[17],
    // force_index[20:18], zero pad above
    function automatic logic [IN_DATA_W-1:0] pack_tick(
        input logic mr, input logic [3:0] tr, input logic [3:0] rise,
        input logic [3:0] fall, input logic [3:0] dir, input logic fv,
        input logic [2:0] fi);
        return {3'b000, fi, fv, dir, fall, rise, tr, mr};
    endfunction

    // Mostly clock traffic; resets kept rare so that tracks get past the
    // guard and walk the whole mode table.
    function automatic logic [IN_DATA_W-1:0] random_tick(input int reset_odds);
        logic [3:0] tr;
        int         t;
        for (t = 0; t < 4; t++)
            tr[t] = ($urandom_range(0, reset_odds) == 0);
        return pack_tick($urandom_range(0, 4 * reset_odds) == 0, tr,
                         4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                         4'($urandom_range(0, 15)), $urandom_range(0, 5) == 0,
                         3'($urandom_range(0, 7)));
    endfunction

    // One transaction on s_axis. Called and left at a falling edge; every
    // fourth block of 48 ticks goes back to back.
    task automatic send_tick(input logic [IN_DATA_W-1:0] payload);
        int gap;
        gap = (((sent_count / 48) % 4) == 1) ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata  <= payload;
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sent_count++;
        @(negedge clk);
    endtask

    task automatic send_fields(input logic mr, input logic [3:0] tr,
                               input logic [3:0] rise, input logic [3:0] fall,
                               input logic [3:0] dir, input logic fv,
                               input logic [2:0] fi);
        send_tick(pack_tick(mr, tr, rise, fall, dir, fv, fi));
    endtask

    // Registers only change with nothing in flight
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (waiting_results != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        @(negedge clk);
    endtask

    // Receiver: random stall per result, calm stretches, one long hold-off
    initial
    begin : receiver
        int stall;
        int taken;
        bit held;
        m_axis_tready = 1'b0;
        taken = 0;
        held  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            stall = (((taken / 64) % 4) == 2) ? 0 : $urandom_range(0, 7);
            if (!held && taken == HOLD_AT)
            begin
                stall = HOLD_CYCLES;
                held  = 1'b1;
            end
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            taken++;
        end
    end

    initial
    begin : stimulus
        logic [15:0] modes;
        logic [3:0]  back;
        logic [15:0] guard;
        int          odds;
        int          p;
        int          n;
        int          drain;
        bit          stuck;

        rst_n         = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tvalid = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = REG_STEP_MODES;
        cfg_wr_data   = '0;
        sent_count    = 0;
        stuck         = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed table: steps 1, 4, 5 skip; 2 code three (normal);
        // 3 return-to-start; track 1 forced backward; two-tick guard.
        write_reg(REG_STEP_MODES, 16'h05B4);
        write_reg(REG_BACKWARD, 16'h0002);
        write_reg(REG_GUARD_TICKS, 16'd2);

        send_fields(1'b1, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 3'd0); // master reset
        send_fields(1'b0, 4'h0, 4'hF, 4'h0, 4'h0, 1'b0, 3'd0); // rise in guard
        send_fields(1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 3'd0); // guard runs out
        send_fields(1'b0, 4'h0, 4'hF, 4'h0, 4'h0, 1'b0, 3'd0); // skip over step 1
        send_fields(1'b0, 4'h0, 4'hF, 4'h0, 4'h0, 1'b0, 3'd0); // onto step 3
        send_fields(1'b0, 4'h0, 4'hF, 4'h0, 4'h0, 1'b0, 3'd0); // return to start
        send_fields(1'b0, 4'h0, 4'h0, 4'hF, 4'h0, 1'b0, 3'd0); // fall all
        send_fields(1'b0, 4'h0, 4'hF, 4'h0, 4'hF, 1'b0, 3'd0); // backward walk
        send_fields(1'b0, 4'h0, 4'hF, 4'hF, 4'hA, 1'b0, 3'd0); // rise beats fall
        send_fields(1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b1, 3'd7); // arm step 7
        send_fields(1'b0, 4'h0, 4'hF, 4'h0, 4'h0, 1'b0, 3'd0); // take step 7
        send_fields(1'b0, 4'h0, 4'h5, 4'h0, 4'h0, 1'b1, 3'd0); // force and rise
        send_fields(1'b0, 4'h0, 4'h3, 4'h0, 4'h0, 1'b1, 3'd4); // force onto skip
        send_fields(1'b0, 4'h9, 4'hF, 4'h0, 4'h0, 1'b0, 3'd0); // track resets
        send_fields(1'b0, 4'h1, 4'hF, 4'h0, 4'h0, 1'b0, 3'd0); // reset in guard
        send_fields(1'b0, 4'h0, 4'hF, 4'h6, 4'h0, 1'b0, 3'd0);
        send_fields(1'b0, 4'h0, 4'hF, 4'h0, 4'h3, 1'b0, 3'd0);
        send_fields(1'b1, 4'hF, 4'hF, 4'hF, 4'hF, 1'b1, 3'd7); // all fields high
        send_fields(1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 3'd0); // all fields low
        send_fields(1'b0, 4'h0, 4'h0, 4'h0, 4'h0, 1'b0, 3'd0);
        send_fields(1'b0, 4'h0, 4'hF, 4'h0, 4'hC, 1'b1, 3'd2);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            // guard at its longest goes last: those tracks stay frozen
            case (p)
                0:       begin modes = 16'h0000; back = 4'h0; guard = 16'd0;  odds = 8;   end
                1:       begin modes = 16'hFFFF; back = 4'hF; guard = 16'd1;  odds = 8;   end
                2:       begin modes = 16'h5555; back = 4'($urandom_range(0, 15));
                               guard = GUARD_TICKS_RST; odds = 150; end
                3:       begin modes = 16'hAAAA; back = 4'($urandom_range(0, 15));
                               guard = 16'd3; odds = 20; end
                NUM_PHASES - 1:
                         begin modes = 16'($urandom_range(0, 65535));
                               back = 4'($urandom_range(0, 15));
                               guard = 16'hFFFF; odds = 300; end
                default: begin modes = 16'($urandom_range(0, 65535));
                               back = 4'($urandom_range(0, 15));
                               guard = 16'($urandom_range(0, 8)); odds = 25; end
            endcase
            settle();
            write_reg(REG_STEP_MODES, modes);
            write_reg(REG_BACKWARD, {12'd0, back});
            write_reg(REG_GUARD_TICKS, guard);
            for (n = 0; n < PHASE_TICKS; n++)
                send_tick(random_tick(odds));
        end

        s_axis_tvalid <= 1'b0;
        for (drain = 0; drain < DRAIN_LIMIT && waiting_results != 0; drain++)
            @(negedge clk);
        if (waiting_results != 0)
        begin
            $display("%0d results never arrived", waiting_results);
            stuck = 1'b1;
        end
        // any stray result in the tail is caught by the checker
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("run covered %0d ticks over %0d register settings, %0d results",
                 sent_count, NUM_PHASES + 1, results_checked);
        $display("tables: all normal, all code three, all skip, all return, random");
        if (fault_count == 0 && !stuck)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: four_track_step_sequencer_unit.f
rtl/ftss_pkg.sv
rtl/ftss_cfg.sv
rtl/ftss_walk.sv
rtl/four_track_step_sequencer_unit.sv
tb/four_track_step_sequencer_unit_checker.sv
tb/four_track_step_sequencer_unit_test.sv
